FILE: hw/rtl/bf5g_pkg.sv
// Shared constants, codes and types of the 5x5 grayscale box filter.
`timescale 1ns / 1ps
package bf5g_pkg;

  localparam int unsigned MAX_COLS   = 1024;
  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LINE_ROWS  = 4;
  localparam int unsigned RAM_W      = LINE_ROWS * PIX_W;
  localparam int unsigned DIM_RESET  = 512;
  localparam int unsigned COL_SUM_W  = 11;
  localparam int unsigned BOX_SUM_W  = 13;
  localparam int unsigned BOX_RECIP  = 5243;
  localparam int unsigned RECIP_W    = 13;
  localparam int unsigned BOX_SHIFT  = 17;
  localparam int unsigned PROD_W     = BOX_SUM_W + RECIP_W;
  localparam int unsigned PIX_MAX    = 255;
  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [0:0] {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } act_e;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic res;
    logic interior;
    logic last;
  } item_flags_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] value;
  } out_word_t;

endpackage

FILE: hw/rtl/bf5g_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module bf5g_ram #(
  parameter int unsigned Width = bf5g_pkg::RAM_W,
  parameter int unsigned Depth = bf5g_pkg::MAX_COLS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/box_filter_5x5_gray.sv
// 5x5 box mean filter for a raster stream of 8-bit grayscale pixels.
//
// The block accepts one word per clock while its output FIFO has room and returns the
// truncated mean of each 5x5 neighbourhood in raster order, zero within two pixels of
// any border, with tlast on the final pixel of the image. Each pixel does one
// read-modify-write of the line store, a RAM of MaxCols words holding four packed rows,
// so the sustained rate is one word per clock while the FIFO has room. A result passes
// through a four-stage pipeline (B, C, D, E) and an eight-word output FIFO before it is
// presented on the output. After the last pixel, at most 2*width+2 drain words flush the
// trailing border zeros. Register writes restart the image and must only be made while
// no word is in flight.
`timescale 1ns / 1ps
module box_filter_5x5_gray #(
  parameter int unsigned MaxCols = bf5g_pkg::MAX_COLS,
  parameter int unsigned MaxRows = bf5g_pkg::MAX_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bf5g_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                   s_axis_tuser,   // [0] action
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bf5g_pkg::PIX_W-1:0]   m_axis_tdata,   // [7:0] value
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [bf5g_pkg::CFG_W-1:0]   cfg_data_i
);
  import bf5g_pkg::*;

  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned ColDimW  = $clog2(MaxCols + 1);
  localparam int unsigned RowDimW  = $clog2(MaxRows + 1);
  localparam int unsigned ColReset = (DIM_RESET > MaxCols) ? MaxCols : DIM_RESET;
  localparam int unsigned RowReset = (DIM_RESET > MaxRows) ? MaxRows : DIM_RESET;
  localparam int unsigned FifoAw   = $clog2(FIFO_DEPTH);
  localparam int unsigned FifoCntW = FifoAw + 2;

  logic                 cfg_acc, in_acc;
  logic [31:0]          cfg_ext;
  logic [ColDimW-1:0]   w_q, w_d;
  logic [RowDimW-1:0]   h_q, h_d;
  logic [ColW-1:0]      in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]      in_row_q, in_row_d, out_row_q, out_row_d;
  logic                 in_done_q, in_done_d;
  logic                 emit_now;
  item_flags_t          flags;

  logic                 b_valid_q;
  item_flags_t          b_flags_q;
  logic [ColW-1:0]      b_col_q;
  logic [1:0]           b_slot_q;
  logic [PIX_W-1:0]     b_pix_q;
  logic                 fwd_hit_q;
  logic [RAM_W-1:0]     fwd_data_q;
  logic [RAM_W-1:0]     ram_rdata, rd_word, ram_wdata;
  logic                 ram_we;
  logic [COL_SUM_W-1:0] col_sum;
  logic [COL_SUM_W-1:0] win_q [5];

  logic                 c_valid_q, c_interior_q, c_last_q;
  logic                 d_valid_q, d_interior_q, d_last_q;
  logic [BOX_SUM_W-1:0] d_sum_q, box_sum;
  logic                 e_valid_q, e_interior_q, e_last_q;
  logic [PROD_W-1:0]    e_prod_q;
  logic [PROD_W-BOX_SHIFT-1:0] quot;
  out_word_t            e_word;

  out_word_t            fifo_q [FIFO_DEPTH];
  logic [FifoAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]  fifo_cnt_q, inflight, credit;
  logic                 fifo_rd;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_ext     = 32'(cfg_data_i);

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          if (cfg_ext == 32'd0) begin
            w_d = ColDimW'(1);
          end else if (cfg_ext > MaxCols) begin
            w_d = ColDimW'(MaxCols);
          end else begin
            w_d = ColDimW'(cfg_ext);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_ext == 32'd0) begin
            h_d = RowDimW'(1);
          end else if (cfg_ext > MaxRows) begin
            h_d = RowDimW'(MaxRows);
          end else begin
            h_d = RowDimW'(cfg_ext);
          end
        end
        default: begin
          w_d = w_q;
        end
      endcase
    end
  end

  assign emit_now = (in_row_q >= RowW'(3) && (w_q >= ColDimW'(2) || in_row_q >= RowW'(4)))
                 || (in_row_q == RowW'(2) && in_col_q >= ColW'(2));

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_done_d = in_done_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    flags     = '0;
    if (cfg_acc) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_done_d = 1'b0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (in_acc) begin
      if (s_axis_tuser == ACT_DRAIN) begin
        flags.res = in_done_q;
      end else if (!in_done_q) begin
        flags.load     = 1'b1;
        flags.res      = emit_now;
        flags.interior = (in_row_q >= RowW'(4)) && (in_col_q >= ColW'(4));
        if (in_col_q == ColW'(w_q - 1'b1)) begin
          in_col_d = '0;
          if (in_row_q == RowW'(h_q - 1'b1)) begin
            in_done_d = 1'b1;
          end else begin
            in_row_d = RowW'(in_row_q + 1'b1);
          end
        end else begin
          in_col_d = ColW'(in_col_q + 1'b1);
        end
      end
      if (flags.res) begin
        flags.last = (out_row_q == RowW'(h_q - 1'b1)) && (out_col_q == ColW'(w_q - 1'b1));
        if (out_col_q == ColW'(w_q - 1'b1)) begin
          out_col_d = '0;
          if (out_row_q == RowW'(h_q - 1'b1)) begin
            in_col_d  = '0;
            in_row_d  = '0;
            in_done_d = 1'b0;
            out_row_d = '0;
          end else begin
            out_row_d = RowW'(out_row_q + 1'b1);
          end
        end else begin
          out_col_d = ColW'(out_col_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= ColDimW'(ColReset);
      h_q       <= RowDimW'(RowReset);
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_done_q <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_done_q <= in_done_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  bf5g_ram #(
    .Width(RAM_W),
    .Depth(MaxCols)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(in_col_q),
    .rdata_o(ram_rdata)
  );

  assign rd_word = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign ram_we  = b_valid_q && b_flags_q.load;

  always_comb begin
    col_sum = COL_SUM_W'(b_pix_q);
    for (int i = 0; i < LINE_ROWS; i++) begin
      col_sum = col_sum + COL_SUM_W'(rd_word[i*PIX_W +: PIX_W]);
      if (b_slot_q == 2'(i)) begin
        ram_wdata[i*PIX_W +: PIX_W] = b_pix_q;
      end else begin
        ram_wdata[i*PIX_W +: PIX_W] = rd_word[i*PIX_W +: PIX_W];
      end
    end
  end

  always_comb begin
    box_sum = '0;
    for (int i = 0; i < 5; i++) begin
      box_sum = box_sum + BOX_SUM_W'(win_q[i]);
    end
  end

  assign quot = e_prod_q[PROD_W-1:BOX_SHIFT];

  always_comb begin
    e_word.last  = e_last_q;
    e_word.value = '0;
    if (e_interior_q) begin
      if (quot > (PROD_W-BOX_SHIFT)'(PIX_MAX)) begin
        e_word.value = PIX_W'(PIX_MAX);
      end else begin
        e_word.value = PIX_W'(quot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_flags_q  <= flags;
    b_col_q    <= in_col_q;
    b_slot_q   <= in_row_q[1:0];
    b_pix_q    <= s_axis_tdata;
    fwd_data_q <= ram_wdata;
    if (ram_we) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= win_q[4];
      win_q[4] <= col_sum;
    end
    c_interior_q <= b_flags_q.interior;
    c_last_q     <= b_flags_q.last;
    d_interior_q <= c_interior_q;
    d_last_q     <= c_last_q;
    d_sum_q      <= box_sum;
    e_interior_q <= d_interior_q;
    e_last_q     <= d_last_q;
    e_prod_q     <= PROD_W'(d_sum_q) * PROD_W'(RECIP_W'(BOX_RECIP));
    if (e_valid_q) begin
      fifo_q[wr_ptr_q] <= e_word;
    end
  end

  assign fifo_rd  = m_axis_tvalid && m_axis_tready;
  assign inflight = FifoCntW'(b_valid_q) + FifoCntW'(c_valid_q)
                  + FifoCntW'(d_valid_q) + FifoCntW'(e_valid_q);
  assign credit   = fifo_cnt_q + inflight;

  assign s_axis_tready = credit < FifoCntW'(FIFO_DEPTH);
  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q].value;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      fwd_hit_q  <= 1'b0;
      c_valid_q  <= 1'b0;
      d_valid_q  <= 1'b0;
      e_valid_q  <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      b_valid_q <= in_acc && !cfg_acc;
      fwd_hit_q <= in_acc && ram_we && (b_col_q == in_col_q);
      c_valid_q <= b_valid_q && b_flags_q.res;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      if (e_valid_q) begin
        wr_ptr_q <= FifoAw'(wr_ptr_q + 1'b1);
      end
      if (fifo_rd) begin
        rd_ptr_q <= FifoAw'(rd_ptr_q + 1'b1);
      end
      fifo_cnt_q <= FifoCntW'(fifo_cnt_q + FifoCntW'(e_valid_q) - FifoCntW'(fifo_rd));
    end
  end

  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(e_valid_q && !fifo_rd && fifo_cnt_q == FifoCntW'(FIFO_DEPTH)))
    else $error("Output FIFO written while full.");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> b_valid_q)
    else $error("Line-store forwarding without an item in the read stage.");

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ColDimW'(in_col_q) < w_q) && (ColDimW'(out_col_q) < w_q))
    else $error("Column counter beyond the image width.");

  a_result_follows_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (fifo_cnt_q + inflight < FifoCntW'(FIFO_DEPTH)))
    else $error("Word accepted without room for its result.");

endmodule
